// File: hw/rtl/rlbd_pkg.sv
// rlbd_pkg: shared types and constants of the run-length byte decoder
// used by every module under hw/rtl; depends on nothing
package rlbd_pkg;

  localparam int unsigned RUN_LIMIT    = 64;
  localparam int unsigned CNT_W        = $clog2(RUN_LIMIT + 1);
  localparam int unsigned CAP_W        = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 16'd256;
  localparam int unsigned Q_DEPTH      = 4;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_DONE     = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    OP_RUN,
    OP_DONE,
    OP_OVERFLOW
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       value;
    logic [CNT_W-1:0] count;
  } cmd_t;

endpackage

// File: hw/rtl/run_length_byte_decoder.sv
// run_length_byte_decoder: top level, capacity register and channel wiring
// depends on rlbd_pkg, rlbd_front, rlbd_queue, rlbd_back
//
//   channel | ports                                         | transfer when
//   input   | in_push in_full in_encoded_byte               | in_push && !in_full
//   result  | out_empty out_pop out_result_kind             | out_pop && !out_empty
//           | out_out_byte out_run_last                     |
//   config  | psel penable pwrite paddr pwdata prdata pready | psel penable pwrite
//
// a count byte within the limits takes no output slot of its own
// a value byte queues a run that leaves the result register at one byte per cycle
// while the result is taken; a status item fills one result slot
// input stalls only when the command queue (Q_DEPTH_P entries) is full
// synchronous active-low reset; capacity returns to 256, the parser to count phase
module run_length_byte_decoder
  import rlbd_pkg::*;
#(
  parameter int unsigned Q_DEPTH_P = Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_encoded_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_out_byte,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CAP_W-1:0] capacity_r;
  logic             in_fire;
  logic             cmd_push;
  cmd_t             cmd;
  logic             q_full;
  logic             head_valid;
  cmd_t             head_cmd;
  logic             head_pop;
  logic             res_valid;
  kind_t            res_kind;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - CAP_W){1'b0}}, capacity_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      capacity_r <= pwdata[CAP_W-1:0];
    end
  end

  assign in_full = q_full;
  assign in_fire = in_push && !q_full;

  rlbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_fire),
    .in_byte  (in_encoded_byte),
    .capacity (capacity_r),
    .cmd_push (cmd_push),
    .cmd      (cmd)
  );

  rlbd_queue #(
    .DEPTH (Q_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (cmd_push),
    .push_cmd   (cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (head_pop)
  );

  rlbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_pop   (head_pop),
    .out_valid  (res_valid),
    .out_kind   (res_kind),
    .out_byte   (out_out_byte),
    .out_last   (out_run_last),
    .out_take   (out_pop)
  );

  assign out_empty       = !res_valid;
  assign out_result_kind = res_kind;

endmodule

// File: hw/rtl/rlbd_front.sv
// rlbd_front: parses the encoded byte stream and checks counts against the run limit and capacity
// depends on rlbd_pkg; feeds commands into rlbd_queue
module rlbd_front
  import rlbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_byte,
  input  logic [CAP_W-1:0] capacity,
  output logic             cmd_push,
  output cmd_t             cmd
);

  typedef enum logic [1:0] {
    PH_COUNT,
    PH_VALUE,
    PH_SKIP_COUNT,
    PH_SKIP_VALUE
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] held_r, held_nxt;
  logic [CAP_W-1:0] total_r, total_nxt;
  logic [CAP_W:0]   sum;

  assign sum = {1'b0, total_r} + {{(CAP_W - 7){1'b0}}, in_byte};

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    total_nxt = total_r;
    cmd_push  = 1'b0;
    cmd.op    = OP_RUN;
    cmd.value = 8'd0;
    cmd.count = held_r;
    if (in_valid) begin
      unique case (phase_r)
        PH_COUNT: begin
          if (in_byte == 8'd0) begin
            cmd_push  = 1'b1;
            cmd.op    = OP_DONE;
            total_nxt = '0;
          end else if (in_byte > 8'(RUN_LIMIT) || sum > {1'b0, capacity}) begin
            cmd_push  = 1'b1;
            cmd.op    = OP_OVERFLOW;
            phase_nxt = PH_SKIP_VALUE;
          end else begin
            held_nxt  = in_byte[CNT_W-1:0];
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          cmd_push  = 1'b1;
          cmd.op    = OP_RUN;
          cmd.value = in_byte;
          total_nxt = total_r + {{(CAP_W - CNT_W){1'b0}}, held_r};
          held_nxt  = '0;
          phase_nxt = PH_COUNT;
        end
        PH_SKIP_COUNT: begin
          if (in_byte == 8'd0) begin
            total_nxt = '0;
            phase_nxt = PH_COUNT;
          end else begin
            phase_nxt = PH_SKIP_VALUE;
          end
        end
        PH_SKIP_VALUE: begin
          phase_nxt = PH_SKIP_COUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT;
      held_r  <= '0;
      total_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      total_r <= total_nxt;
    end
  end

endmodule

// File: hw/rtl/rlbd_queue.sv
// rlbd_queue: short command queue between parser and expander
// depends on rlbd_pkg for the command type
module rlbd_queue
  import rlbd_pkg::*;
#(
  parameter int unsigned DEPTH = Q_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: hw/rtl/rlbd_back.sv
// rlbd_back: expands queued commands into result items, one per cycle while the result slot is free
// depends on rlbd_pkg; drains rlbd_queue into the result register
module rlbd_back
  import rlbd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       head_pop,
  output logic       out_valid,
  output kind_t      out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       out_take
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [7:0]       run_byte_r, run_byte_nxt;
  logic             valid_r, valid_nxt;
  kind_t            kind_r, kind_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             slot_free;

  assign slot_free = !valid_r || out_take;

  always_comb begin
    busy_nxt     = busy_r;
    left_nxt     = left_r;
    run_byte_nxt = run_byte_r;
    valid_nxt    = valid_r;
    kind_nxt     = kind_r;
    byte_nxt     = byte_r;
    last_nxt     = last_r;
    head_pop     = 1'b0;
    if (slot_free) begin
      if (busy_r) begin
        valid_nxt = 1'b1;
        kind_nxt  = KIND_DATA;
        byte_nxt  = run_byte_r;
        last_nxt  = (left_r == CNT_W'(1));
        busy_nxt  = (left_r != CNT_W'(1));
        left_nxt  = left_r - 1'b1;
      end else if (head_valid) begin
        head_pop  = 1'b1;
        valid_nxt = 1'b1;
        unique case (head_cmd.op)
          OP_RUN: begin
            kind_nxt     = KIND_DATA;
            byte_nxt     = head_cmd.value;
            last_nxt     = (head_cmd.count == CNT_W'(1));
            busy_nxt     = (head_cmd.count != CNT_W'(1));
            left_nxt     = head_cmd.count - 1'b1;
            run_byte_nxt = head_cmd.value;
          end
          OP_DONE: begin
            kind_nxt = KIND_DONE;
            byte_nxt = 8'd0;
            last_nxt = 1'b1;
          end
          default: begin
            kind_nxt = KIND_OVERFLOW;
            byte_nxt = 8'd0;
            last_nxt = 1'b1;
          end
        endcase
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      left_r  <= '0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
      left_r  <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    kind_r     <= kind_nxt;
    byte_r     <= byte_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;

endmodule

// File: tb/sv/run_length_byte_decoder_tb.sv
// run_length_byte_decoder_tb: self-checking testbench for the run-length byte decoder
// checks every decoded byte and buffer status against a behavioral predictor
// depends on rlbd_pkg and run_length_byte_decoder
module run_length_byte_decoder_tb
  import rlbd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CAPACITY_ADDR = 3'd0;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {
    EXPECT_COUNT,
    EXPECT_VALUE,
    SKIP_COUNT,
    SKIP_VALUE
  } parse_phase_e;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } decoded_t;

  class rl_scoreboard;
    decoded_t     pending[$];
    logic [15:0]  capacity;
    parse_phase_e phase;
    logic [7:0]   held_count;
    logic [15:0]  buffer_total;
    int           errors;
    int           n_bytes;
    int           n_data;
    int           n_done;
    int           n_overflow;

    function new();
      capacity = CAP_RESET;
      phase = EXPECT_COUNT;
      held_count = '0;
      buffer_total = '0;
      errors = 0;
      n_bytes = 0;
      n_data = 0;
      n_done = 0;
      n_overflow = 0;
    endfunction

    function void add(kind_t kind, logic [7:0] data, logic last);
      decoded_t d;
      d.kind = kind;
      d.data = data;
      d.last = last;
      pending.push_back(d);
    endfunction

    function void note_input(logic [7:0] b);
      logic [16:0] needed;
      needed = {1'b0, buffer_total} + {9'd0, b};
      n_bytes++;
      case (phase)
        EXPECT_COUNT: begin
          if (b == 8'd0) begin
            add(KIND_DONE, 8'd0, 1'b1);
            buffer_total = '0;
          end else if (b > RUN_LIMIT || needed > {1'b0, capacity}) begin
            add(KIND_OVERFLOW, 8'd0, 1'b1);
            phase = SKIP_VALUE;
          end else begin
            held_count = b;
            phase = EXPECT_VALUE;
          end
        end
        EXPECT_VALUE: begin
          for (int j = 0; j < held_count; j++) begin
            add(KIND_DATA, b, (j + 1 == held_count));
          end
          buffer_total = buffer_total + {8'd0, held_count};
          held_count = '0;
          phase = EXPECT_COUNT;
        end
        SKIP_COUNT: begin
          if (b == 8'd0) begin
            buffer_total = '0;
            phase = EXPECT_COUNT;
          end else begin
            phase = SKIP_VALUE;
          end
        end
        default: phase = SKIP_COUNT;
      endcase
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last);
      decoded_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind %0d byte 0x%02h last %0b",
                 $time, kind, data, last);
        return;
      end
      exp = pending.pop_front();
      if (kind !== exp.kind) begin
        errors++;
        $display("%0t: result_kind expected %0d actual %0d", $time, exp.kind, kind);
      end
      if (data !== exp.data) begin
        errors++;
        $display("%0t: out_byte expected 0x%02h actual 0x%02h", $time, exp.data, data);
      end
      if (last !== exp.last) begin
        errors++;
        $display("%0t: run_last expected %0b actual %0b", $time, exp.last, last);
      end
      case (exp.kind)
        KIND_DATA: n_data++;
        KIND_DONE: n_done++;
        default:   n_overflow++;
      endcase
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_encoded_byte = 8'd0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_out_byte;
  logic        out_run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  rl_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;

  run_length_byte_decoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_encoded_byte (in_encoded_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_kind (out_result_kind),
    .out_out_byte    (out_out_byte),
    .out_run_last    (out_run_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    out_pop = ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      sb.check_result(out_result_kind, out_out_byte, out_run_last);
    end
    if ((in_push && !in_full) || (rst_n && out_pop && !out_empty) || (psel && penable)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("run_length_byte_decoder_tb: FAIL");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push = 1'b0;
      @(negedge clk);
    end
    in_push = 1'b1;
    in_encoded_byte = b;
    do @(posedge clk); while (in_full);
    sb.note_input(b);
    @(negedge clk);
  endtask

  task automatic send_seq(logic [7:0] seq[$]);
    foreach (seq[i]) begin
      send_byte(seq[i]);
    end
  endtask

  task automatic drain();
    in_push = 1'b0;
    while (sb.pending.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == CAPACITY_ADDR) begin
      sb.capacity = data[15:0];
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic cfg_read_check(logic [2:0] addr);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== sb.capacity) begin
      sb.errors++;
      $display("%0t: capacity readback expected %0d actual %0d",
               $time, sb.capacity, prdata[15:0]);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_capacity(logic [15:0] cap);
    cfg_write(CAPACITY_ADDR, {16'd0, cap});
    cfg_read_check(CAPACITY_ADDR);
  endtask

  function automatic logic [7:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return 8'($urandom_range(1, 16));
    if (r < 88) return 8'($urandom_range(17, 64));
    if (r < 95) return 8'($urandom_range(65, 255));
    return 8'd0;
  endfunction

  task automatic send_random(int budget, bit hold_midway);
    int target;
    int pairs;
    bit held;
    target = sb.n_bytes + budget;
    held = 1'b0;
    while (sb.n_bytes < target) begin
      if (hold_midway && !held && sb.n_bytes >= target - budget / 2) begin
        held = 1'b1;
        in_push = 1'b0;
        while (sb.pending.size() != 0) begin
          @(negedge clk);
        end
      end
      if ($urandom_range(0, 99) < 10) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        pairs = $urandom_range(1, 6);
        for (int p = 0; p < pairs; p++) begin
          send_byte(pick_count());
          send_byte(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 85) begin
          send_byte(8'd0);
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    cfg_read_check(CAPACITY_ADDR);

    // terminator, shortest and longest runs, run limit overflow with discard
    send_seq('{8'd0, 8'd1, 8'h00, 8'd64, 8'hFF, 8'd65, 8'hAA, 8'd3, 8'h55, 8'd0});
    drain();
    set_capacity(16'd0);
    send_seq('{8'd1, 8'h12, 8'd0, 8'd0});
    drain();
    set_capacity(16'hFFFF);
    send_seq('{8'd255, 8'h80, 8'd0, 8'd64, 8'h7F, 8'd0});
    drain();
    // exact fill of the capacity, then one byte over
    set_capacity(16'd70);
    send_seq('{8'd64, 8'h01, 8'd6, 8'h02, 8'd1, 8'h03, 8'd0});
    drain();
    // capacity lowered in the middle of a buffer
    set_capacity(16'd256);
    send_seq('{8'd5, 8'hC3});
    drain();
    set_capacity(16'd8);
    send_seq('{8'd4, 8'h3C, 8'd0});
    drain();

    set_capacity(16'd120);
    send_idle_pct = 17;
    recv_idle_pct = 88;
    send_random(66, 1'b1);
    drain();

    set_capacity(16'd48);
    send_idle_pct = 88;
    recv_idle_pct = 17;
    send_random(66, 1'b0);
    drain();

    set_capacity(16'($urandom_range(200, 600)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(66, 1'b0);
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d encoded bytes: %0d data bytes, %0d buffer ends, %0d overflows",
             sb.n_bytes, sb.n_data, sb.n_done, sb.n_overflow);
    $display("capacities 256, 0, 65535, 70, 8 and random values under three idling mixes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("run_length_byte_decoder_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d results still expected", sb.errors, sb.pending.size());
      $display("run_length_byte_decoder_tb: FAIL");
    end
    $finish;
  end

endmodule
